// ===== rtl/core/double_ended_queue_defines.svh =====
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed one cycle later");

`endif

// ===== rtl/core/deq_pkg.sv =====
// Types and codes shared by the double-ended queue and its cells.
package deq_pkg;

    localparam int WORD_W = 32;

    localparam logic [2:0] MODE_LIST       = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_ROTATE
    } cmd_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic                     valid;
        logic signed [WORD_W-1:0] data;
    } link_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
// One storage cell of the queue row; it trades its word with its neighbors.
module deq_cell
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic signed [WORD_W-1:0] push_value,
    input  logic signed [WORD_W-1:0] head_data,
    input  link_t                    left,
    input  link_t                    right,
    output link_t                    own
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                valid_next = left.valid;
                data_next  = left.data;
            end
            CMD_PUSH_BACK:
            begin
                // The first free cell after the stored words takes the item.
                if (left.valid && !valid_reg)
                begin
                    valid_next = 1'b1;
                    data_next  = push_value;
                end
            end
            CMD_POP_FRONT:
            begin
                valid_next = right.valid;
                data_next  = right.data;
            end
            CMD_POP_BACK:
            begin
                if (valid_reg && !right.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_ROTATE:
            begin
                // The tail cell wraps the head word around.
                if (valid_reg)
                begin
                    data_next = right.valid ? right.data : head_data;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign own.valid = valid_reg;
    assign own.data  = data_reg;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Double-ended queue built as a row of shifting cells, with its command sequencer.
// Push and pop items are taken while idle; their single result comes on the next cycle.
// A list item yields one result per stored word, one per cycle, front to back; busy stays
// high until the walk reaches the last word, and the row rotates one place per cycle.
// Results cannot be held off; each is shown for one cycle with strobe high.
// Reset clears every cell's valid bit, so the queue comes out of reset empty.
`include "double_ended_queue_defines.svh"

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               mode,
    input  logic signed [WORD_W-1:0] value,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] value_res,
    output logic                     is_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Sequencer states: idle takes items, walk streams the remaining listed words.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    // Cell links: cell i holds the i-th word counted from the front.
    link_t cell_q [DEPTH];
    link_t left_l [DEPTH];
    link_t right_l [DEPTH];
    logic [DEPTH-1:0] valid_vec;

    cmd_t cmd;

    logic                     state_reg;
    logic                     state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         remain_reg;
    logic [CNT_W-1:0]         remain_next;
    logic                     strobe_reg;
    logic                     strobe_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic signed [WORD_W-1:0] value_res_reg;
    logic signed [WORD_W-1:0] value_res_next;
    logic                     is_last_reg;
    logic                     is_last_next;

    logic                     empty;
    logic                     full;
    logic                     accept;
    logic signed [WORD_W-1:0] tail_data;

    // The row of cells; the first cell sees the pushed word as its left neighbor,
    // and the last cell sees an empty right neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_l[i] = '{valid: 1'b1, data: value};
        end
        else
        begin : g_mid_left
            assign left_l[i] = cell_q[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_l[i] = '{valid: 1'b0, data: '0};
        end
        else
        begin : g_mid_right
            assign right_l[i] = cell_q[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .push_value (value),
            .head_data  (cell_q[0].data),
            .left       (left_l[i]),
            .right      (right_l[i]),
            .own        (cell_q[i])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    assign empty  = !valid_vec[0];
    assign full   = valid_vec[DEPTH-1];
    assign busy   = (state_reg == S_WALK);
    assign accept = start && !busy;

    // The back word sits in the only valid cell whose right neighbor is empty.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_q[i].valid && !right_l[i].valid)
            begin
                tail_data = tail_data | cell_q[i].data;
            end
        end
    end

    always_comb
    begin
        cmd            = CMD_HOLD;
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        strobe_next    = 1'b0;
        status_next    = ST_OK;
        value_res_next = '0;
        is_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_LIST:
                        begin
                            strobe_next = 1'b1;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // Emit the head now and rotate; the rest follows in walk.
                                cmd            = CMD_ROTATE;
                                value_res_next = cell_q[0].data;
                                is_last_next   = (count_reg == CNT_W'(1));
                                remain_next    = count_reg - CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = S_WALK;
                                end
                            end
                        end
                        MODE_PUSH_FRONT, MODE_PUSH_BACK:
                        begin
                            strobe_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd        = (mode == MODE_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                       : CMD_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK:
                        begin
                            strobe_next = 1'b1;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd            = (mode == MODE_POP_FRONT) ? CMD_POP_FRONT
                                                                          : CMD_POP_BACK;
                                value_res_next = (mode == MODE_POP_FRONT) ? cell_q[0].data
                                                                          : tail_data;
                                count_next     = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            // Unused modes are taken and dropped without a result.
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // Each cycle shows the current head and rotates the row one place;
                // after count rotations the order is back where it started.
                cmd            = CMD_ROTATE;
                strobe_next    = 1'b1;
                value_res_next = cell_q[0].data;
                is_last_next   = (remain_reg == CNT_W'(1));
                remain_next    = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        value_res_reg <= value_res_next;
        is_last_reg   <= is_last_next;
    end

    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign value_res = value_res_reg;
    assign is_last   = is_last_reg;

    // Stored words always fill a contiguous run of cells from the front.
    `DEQ_ASSERT_NOW(a_valid_prefix, clk, rst_n, 1'b1, ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    // The entry count tracks the number of occupied cells.
    `DEQ_ASSERT_NOW(a_count_match, clk, rst_n, 1'b1, $countones(valid_vec) == int'(count_reg))
    // Every cycle of a list walk delivers a result.
    `DEQ_ASSERT_NEXT(a_walk_result, clk, rst_n, busy, strobe)
    // A defined mode taken while idle produces a result on the next cycle.
    `DEQ_ASSERT_NEXT(a_item_result, clk, rst_n, accept && (mode <= MODE_POP_BACK), strobe)

endmodule

// ===== sim/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue: directed and random items against a predictor.
`timescale 1ns / 100ps

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int DEPTH = 32;

    // With no result for this many cycles and no item taken, the block is assumed hung.
    localparam int STALL_LIMIT = 1000;

    // Cycles allowed after the last expected result for anything stray to show up.
    localparam int DRAIN_CYCLES = 40;

    // One expected result, as the block should show it on its result ports.
    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } reply_t;

    // The tracker keeps its own ring of stored words and turns every item the block
    // takes into the results it must produce; results are then checked in order.
    class deque_tracker;
        logic signed [WORD_W-1:0] words [DEPTH];
        int unsigned              head;
        int unsigned              fill;
        reply_t                   replies_due [$];
        int unsigned              failures;

        function int unsigned stored();
            return fill;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        function void note_item(logic [2:0] cmd, logic signed [WORD_W-1:0] word);
            reply_t      r;
            int unsigned k;
            r.status = ST_OK;
            r.word   = '0;
            r.last   = 1'b1;
            case (cmd)
                MODE_LIST:
                begin
                    if (fill == 0)
                    begin
                        r.status = ST_EMPTY;
                        replies_due.push_back(r);
                    end
                    else
                    begin
                        for (k = 0; k < fill; k++)
                        begin
                            r.word = words[(head + k) % DEPTH];
                            r.last = (k + 1 == fill);
                            replies_due.push_back(r);
                        end
                    end
                end
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    if (fill == DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (cmd == MODE_PUSH_FRONT)
                        begin
                            head = (head + DEPTH - 1) % DEPTH;
                            words[head] = word;
                        end
                        else
                            words[(head + fill) % DEPTH] = word;
                        fill++;
                    end
                    replies_due.push_back(r);
                end
                MODE_POP_FRONT, MODE_POP_BACK:
                begin
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        if (cmd == MODE_POP_FRONT)
                        begin
                            r.word = words[head];
                            head = (head + 1) % DEPTH;
                        end
                        else
                            r.word = words[(head + fill - 1) % DEPTH];
                        fill--;
                    end
                    replies_due.push_back(r);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic signed [WORD_W-1:0] word, logic last);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d value %0d last %0b",
                         $time, st, word, last);
                failures++;
                return;
            end
            want = replies_due.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
                failures++;
            end
            if (word !== want.word)
            begin
                $display("%0t: value_res mismatch, expected %0d, actual %0d",
                         $time, want.word, word);
                failures++;
            end
            if (last !== want.last)
            begin
                $display("%0t: is_last mismatch, expected %0b, actual %0b", $time, want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               mode;
    logic signed [WORD_W-1:0] value;
    logic                     strobe;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] value_res;
    logic                     is_last;

    deque_tracker book;

    // While set, the sender never pauses between items.
    bit no_gaps;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .value(value),
        .strobe(strobe),
        .status(status),
        .value_res(value_res),
        .is_last(is_last)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    // Reads here happen before the block's registers update at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            book.check_result(status, value_res, is_last);
    end

    // The watchdog restarts whenever an item is taken or a result is shown.
    int idle_run;
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("double_ended_queue_tb failed");
            $finish;
        end
    end

    // Called just after a falling edge. Holds the item on the ports until the block is
    // not busy at a rising edge, which is when it is taken. Returns at the next falling
    // edge, possibly after a one-cycle pause with start low.
    task automatic send_item(input logic [2:0] cmd, input logic signed [WORD_W-1:0] word);
        start <= 1'b1;
        mode  <= cmd;
        value <= word;
        do
            @(posedge clk);
        while (busy);
        book.note_item(cmd, word);
        @(negedge clk);
        if (!no_gaps && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Mostly random words, with the sign extremes, zero and all ones mixed in.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return {1'b1, {(WORD_W-1){1'b0}}};
            1: return {1'b0, {(WORD_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned n;
        int unsigned r;
        logic [2:0]  cmd;
        bit          grow;

        book    = new;
        no_gaps = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        mode    = MODE_LIST;
        value   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: everything on an empty queue first, then the word extremes
        // at both ends, listing, the unused modes, and removing the only stored word.
        send_item(MODE_LIST, '0);
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_POP_BACK, '1);
        send_item(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
        send_item(MODE_PUSH_FRONT, 32'sh8000_0000);
        send_item(MODE_PUSH_BACK, '1);
        send_item(MODE_PUSH_FRONT, '0);
        send_item(MODE_LIST, 32'sh5555_AAAA);
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_POP_BACK, '0);
        send_item(MODE_LIST, '0);
        send_item(MODE_PUSH_FRONT, 32'sh5A5A_A5A5);
        send_item(3'd5, pick_word());
        send_item(3'd6, pick_word());
        send_item(3'd7, pick_word());
        send_item(MODE_LIST, '0);
        send_item(MODE_POP_BACK, '0);
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_POP_BACK, '0);
        // The queue is empty again here; the front position is kept.
        send_item(MODE_POP_FRONT, '0);
        send_item(MODE_LIST, '0);
        send_item(MODE_PUSH_FRONT, 32'sh1234_5678);
        send_item(MODE_LIST, '0);
        send_item(MODE_POP_BACK, '0);

        // Random part. The queue alternates between a growing phase, mostly pushes, and
        // a shrinking phase, mostly pops, so that it runs full and empty several times;
        // a phase turns only at the full or empty boundary, with one chance in four per item. Lists
        // and the unused modes are sprinkled throughout.
        grow = 1'b1;
        for (n = 0; n < 450; n++)
        begin
            no_gaps = (n >= 150 && n < 260);
            r = $urandom_range(99);
            if (r < 3)
                cmd = 3'($urandom_range(7, 5));
            else if (r < 12)
                cmd = MODE_LIST;
            else if (grow ? (r < 75) : (r >= 75))
                cmd = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            else
                cmd = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
            send_item(cmd, pick_word());
            if (book.stored() == DEPTH && $urandom_range(3) == 0)
                grow = 1'b0;
            if (book.stored() == 0 && $urandom_range(3) == 0)
                grow = 1'b1;
        end
        start <= 1'b0;

        // Wait for every outstanding result, then a little longer so that any
        // extra result would still be caught.
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.failures == 0)
            $display("double_ended_queue_tb passed");
        else
            $display("double_ended_queue_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue.sv
sim/double_ended_queue_tb.sv
